### design/rotation_invariant_lbp_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotation-invariant LBP block
// Shared concurrent-check forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ROTATION_INVARIANT_LBP_DEFINES_SVH
`define ROTATION_INVARIANT_LBP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RILBP_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RILBP_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/rilbp_pkg.sv
// ----------------------------------------------------------------------------
// rilbp_pkg
// Constants and shared types for the rotation-invariant LBP block.
// ----------------------------------------------------------------------------
package rilbp_pkg;

	// Largest supported row length and the pixel depth.
	localparam int MAX_WIDTH    = 1024;
	localparam int PIX_W        = 8;
	localparam int COL_W        = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W        = 12;
	localparam int CODE_W       = 8;

	// Configuration port.
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 12;
	localparam int CFG_DATA_W   = 12;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// One line store entry: the pixel one row above and two rows above.
	typedef struct packed {
		logic [PIX_W-1:0] above;
		logic [PIX_W-1:0] above2;
	} line_entry_t;

	// Read and write request to the line store.
	typedef struct packed {
		logic              we;
		logic [COL_W-1:0]  waddr;
		line_entry_t       wdata;
		logic              re;
		logic [COL_W-1:0]  raddr;
	} line_req_t;

endpackage

### design/rilbp_line_mem.sv
// ----------------------------------------------------------------------------
// rilbp_line_mem
// Line store holding the two previous rows, one entry per column, with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module rilbp_line_mem import rilbp_pkg::*; (
	input  logic        clk,
	input  line_req_t   req,
	output line_entry_t rdata_q
);

	line_entry_t mem_q [MAX_WIDTH];

	// Write and read in the same clocked block; read data appears next cycle.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

endmodule

### design/rotation_invariant_lbp.sv
// ----------------------------------------------------------------------------
// rotation_invariant_lbp
// Streaming 3x3 rotation-invariant local binary pattern over raster pixels.
// ----------------------------------------------------------------------------
// Pixels enter on the pixel channel (pixel_valid/pixel_ready) in raster
// order. Each interior pixel yields one code on the result channel
// (code_valid/code_ready) with row_last and frame_last flags; border pixels
// yield nothing. Registers image_width (index 0) and image_height (index 1)
// are written over the cfg channel; the user must write them only while the
// block is idle, and the block itself does not enforce it. Every accepted
// write to either register restarts the frame at column 0, row 0. A pixel's
// line store read is issued at acceptance and written back from stage 1;
// stage 2 and the output register follow; one pixel per cycle unless stalled.
// Reset clears the counters and the pipeline valid bits and sets width and
// height to 3. The line store is not cleared: the first two rows of every
// frame overwrite each entry before it is used for a result.
// When the receiver stalls a result, the whole pipeline holds and
// pixel_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "rotation_invariant_lbp_defines.svh"

module rotation_invariant_lbp import rilbp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  code_valid,
	input  logic                  code_ready,
	output logic [CODE_W-1:0]     code,
	output logic                  row_last,
	output logic                  frame_last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Smallest of the eight circular rotations of a code.
	function automatic logic [CODE_W-1:0] rot_min(input logic [CODE_W-1:0] c);
		logic [CODE_W-1:0] best;
		logic [CODE_W-1:0] r;
		best = c;
		r    = c;
		for (int k = 0; k < CODE_W - 1; k++) begin
			r = {r[CODE_W-2:0], r[CODE_W-1]};
			if (r < best) best = r;
		end
		return best;
	endfunction

	logic [COL_W-1:0]  width_last_q;
	logic [ROW_W-1:0]  height_last_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	logic              advance;
	logic              accept;
	logic              cfg_write;
	logic              in_last_col;
	logic              in_last_row;

	logic              valid_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [COL_W-1:0]  col_s1;
	logic              emit_s1;
	logic              rl_s1;
	logic              fl_s1;

	logic              valid_s2;
	logic [CODE_W-1:0] code_s2;
	logic              rl_s2;
	logic              fl_s2;

	logic              out_valid_q;
	logic [CODE_W-1:0] code_q;
	logic              row_last_q;
	logic              frame_last_q;

	logic [PIX_W-1:0]  a_q [3];
	logic [PIX_W-1:0]  b_q [3];

	line_req_t         mem_req;
	line_entry_t       mem_rdata;
	logic [CODE_W-1:0] code_raw;
	logic [PIX_W-1:0]  center;

	logic [WIDTH_REG_W-1:0]  wr_width;
	logic [HEIGHT_REG_W-1:0] wr_height;

	// Handshake: the pipeline moves unless a result is held by the receiver.
	assign advance     = !out_valid_q || code_ready;
	assign pixel_ready = advance;
	assign accept      = pixel_valid && advance;
	assign cfg_ready   = 1'b1;
	assign cfg_write   = cfg_valid;

	assign in_last_col = (col_q == width_last_q);
	assign in_last_row = (row_q == height_last_q);

	assign wr_width  = cfg_data[WIDTH_REG_W-1:0];
	assign wr_height = cfg_data[HEIGHT_REG_W-1:0];

	// Configuration registers hold the clamped last column and last row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_last_q  <= COL_W'(2);
			height_last_q <= ROW_W'(2);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					if (wr_width < WIDTH_REG_W'(3)) begin
						width_last_q <= COL_W'(2);
					end else if (32'(wr_width) > MAX_WIDTH) begin
						width_last_q <= COL_W'(MAX_WIDTH - 1);
					end else begin
						width_last_q <= COL_W'(32'(wr_width) - 1);
					end
				end
				REG_IMAGE_HEIGHT: begin
					if (wr_height < HEIGHT_REG_W'(3)) begin
						height_last_q <= ROW_W'(2);
					end else begin
						height_last_q <= ROW_W'(wr_height - HEIGHT_REG_W'(1));
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Column and row counters; a known register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_write && (cfg_index == REG_IMAGE_WIDTH ||
				cfg_index == REG_IMAGE_HEIGHT)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (in_last_col) begin
				col_q <= '0;
				row_q <= in_last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage 1 control: the request whose line store read is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	// Stage 1 payload, captured with the read.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel;
			col_s1  <= col_q;
			emit_s1 <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
			rl_s1   <= in_last_col;
			fl_s1   <= in_last_col && in_last_row;
		end
	end

	// Line store: read at acceptance, write back the shifted column from stage 1 as the pipeline advances.
	assign mem_req.re           = accept;
	assign mem_req.raddr        = col_q;
	assign mem_req.we           = valid_s1 && advance;
	assign mem_req.waddr        = col_s1;
	assign mem_req.wdata.above  = pix_s1;
	assign mem_req.wdata.above2 = mem_rdata.above;

	rilbp_line_mem u_line_mem (
		.clk     (clk),
		.req     (mem_req),
		.rdata_q (mem_rdata)
	);

	// Neighbor comparisons against the center of the shifted window.
	assign center   = b_q[1];
	assign code_raw = {a_q[0] >= center, b_q[0] >= center,
			mem_rdata.above2 >= center, mem_rdata.above >= center,
			pix_s1 >= center, b_q[2] >= center,
			a_q[2] >= center, a_q[1] >= center};

	// Window columns: a holds the older, b the newer of the last two columns.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			a_q[0] <= b_q[0];
			a_q[1] <= b_q[1];
			a_q[2] <= b_q[2];
			b_q[0] <= mem_rdata.above2;
			b_q[1] <= mem_rdata.above;
			b_q[2] <= pix_s1;
		end
	end

	// Stage 2: raw comparison code for interior pixels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			code_s2 <= code_raw;
			rl_s2   <= rl_s1;
			fl_s2   <= fl_s1;
		end
	end

	// Output register: rotation minimum, held while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			code_q       <= rot_min(code_s2);
			row_last_q   <= rl_s2;
			frame_last_q <= fl_s2;
		end
	end

	assign code_valid = out_valid_q;
	assign code       = code_q;
	assign row_last   = row_last_q;
	assign frame_last = frame_last_q;

	// Checks on counters, write-back hazards and flag consistency.
	`RILBP_CHECK_NOW(a_col_in_range, 1'b1, col_q <= width_last_q, "column count past row end")
	`RILBP_CHECK_NEXT(a_frame_wrap, accept && in_last_col && in_last_row && !cfg_write,
		col_q == '0 && row_q == '0, "counters did not wrap at frame end")
	`RILBP_CHECK_NOW(a_no_rw_overlap, mem_req.we && mem_req.re,
		mem_req.waddr != mem_req.raddr, "line store read and write on one entry")
	`RILBP_CHECK_NOW(a_frame_implies_row, out_valid_q && frame_last_q, row_last_q,
		"frame end flag without row end flag")

endmodule

### sim/rotation_invariant_lbp_test.sv
// ----------------------------------------------------------------------------
// rotation_invariant_lbp_test
// Self-checking bench for the streaming rotation-invariant LBP block. Pixel
// frames of many sizes go in through the pixel channel. A scoreboard keeps
// its own line stores, window and counters, predicts every interior code
// with its row and frame flags, and compares each returned code against the
// oldest prediction. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module rotation_invariant_lbp_test import rilbp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              row_last;
		logic              frame_last;
	} lbp_result_t;

	// Scoreboard: mirrors the block state and holds the codes still to come.
	class rilbp_scoreboard;
		logic [PIX_W-1:0]        above_row [MAX_WIDTH];
		logic [PIX_W-1:0]        above2_row [MAX_WIDTH];
		logic [PIX_W-1:0]        win [3][3];
		int unsigned             col_pos;
		int unsigned             row_pos;
		logic [WIDTH_REG_W-1:0]  width_reg;
		logic [HEIGHT_REG_W-1:0] height_reg;
		lbp_result_t             expected_codes [$];
		int                      errors;

		function new();
			foreach (above_row[i]) begin
				above_row[i] = '0;
				above2_row[i] = '0;
			end
			foreach (win[r, c]) win[r][c] = '0;
			col_pos = 0;
			row_pos = 0;
			width_reg = WIDTH_REG_W'(3);
			height_reg = HEIGHT_REG_W'(3);
			errors = 0;
		endfunction

		// Row length and row count as the block uses them after clamping.
		function int unsigned frame_width();
			if (width_reg < 3) return 3;
			if (width_reg > MAX_WIDTH) return MAX_WIDTH;
			return 32'(width_reg);
		endfunction

		function int unsigned frame_height();
			if (height_reg < 3) return 3;
			return 32'(height_reg);
		endfunction

		function int pending();
			return expected_codes.size();
		endfunction

		// Only the two known indexes take effect; each restarts the frame.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_IMAGE_WIDTH) begin
				width_reg = data[WIDTH_REG_W-1:0];
			end else if (idx == REG_IMAGE_HEIGHT) begin
				height_reg = data[HEIGHT_REG_W-1:0];
			end else begin
				return;
			end
			col_pos = 0;
			row_pos = 0;
		endfunction

		function logic [CODE_W-1:0] min_rotation(logic [CODE_W-1:0] pattern);
			logic [CODE_W-1:0] best;
			best = pattern;
			repeat (7) begin
				pattern = {pattern[CODE_W-2:0], pattern[CODE_W-1]};
				if (pattern < best) best = pattern;
			end
			return best;
		endfunction

		// Slide the window by one pixel and predict the code it yields, if any.
		function void note_pixel(logic [PIX_W-1:0] pix);
			int unsigned       w;
			int unsigned       h;
			int unsigned       c;
			int unsigned       r;
			logic [PIX_W-1:0]  ctr;
			logic [CODE_W-1:0] pattern;
			lbp_result_t       res;
			w = frame_width();
			h = frame_height();
			c = (col_pos >= w) ? w - 1 : col_pos;
			r = (row_pos >= h) ? h - 1 : row_pos;
			for (int k = 0; k < 3; k++) begin
				win[k][0] = win[k][1];
				win[k][1] = win[k][2];
			end
			win[0][2] = above2_row[c];
			win[1][2] = above_row[c];
			win[2][2] = pix;
			above2_row[c] = above_row[c];
			above_row[c] = pix;

			// Neighbors clockwise from top-left, top-left in the MSB.
			if (r >= 2 && c >= 2) begin
				ctr = win[1][1];
				pattern = {win[0][0] >= ctr, win[0][1] >= ctr, win[0][2] >= ctr,
					win[1][2] >= ctr, win[2][2] >= ctr, win[2][1] >= ctr,
					win[2][0] >= ctr, win[1][0] >= ctr};
				res.code = min_rotation(pattern);
				res.row_last = (c == w - 1);
				res.frame_last = (c == w - 1) && (r == h - 1);
				expected_codes.push_back(res);
			end

			if (c == w - 1) begin
				c = 0;
				r = (r == h - 1) ? 0 : r + 1;
			end else begin
				c++;
			end
			col_pos = c;
			row_pos = r;
		endfunction

		function void check_code(logic [CODE_W-1:0] code, logic row_last, logic frame_last);
			lbp_result_t exp_res;
			if (expected_codes.size() == 0) begin
				$display("%0t: unexpected code %h (row_last %b, frame_last %b)",
					$time, code, row_last, frame_last);
				errors++;
				return;
			end
			exp_res = expected_codes.pop_front();
			if (code !== exp_res.code) begin
				$display("%0t: code mismatch: expected %h, actual %h",
					$time, exp_res.code, code);
				errors++;
			end
			if (row_last !== exp_res.row_last) begin
				$display("%0t: row_last mismatch: expected %b, actual %b",
					$time, exp_res.row_last, row_last);
				errors++;
			end
			if (frame_last !== exp_res.frame_last) begin
				$display("%0t: frame_last mismatch: expected %b, actual %b",
					$time, exp_res.frame_last, frame_last);
				errors++;
			end
		endfunction
	endclass

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum int {PIX_FULL, PIX_NARROW, PIX_BINARY} pix_style_t;

	// Indexes that map to no register.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_PIXELS = 1900;
	localparam int TALL_ROWS     = 20;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  pixel_valid;
	logic                  pixel_ready;
	logic [PIX_W-1:0]      pixel;
	logic                  code_valid;
	logic                  code_ready;
	logic [CODE_W-1:0]     code;
	logic                  row_last;
	logic                  frame_last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rilbp_scoreboard sb;
	int              sender_idle_pct;
	int              receiver_stall_pct;
	int              random_sent;

	rotation_invariant_lbp u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.code_valid  (code_valid),
		.code_ready  (code_ready),
		.code        (code),
		.row_last    (row_last),
		.frame_last  (frame_last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: check accepted codes and stall at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			code_ready <= 1'b0;
		end else begin
			if (code_valid && code_ready) sb.check_code(code, row_last, frame_last);
			code_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Generous limit on the whole run.
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			IDLE_SENDER: begin
				sender_idle_pct = 58;
				receiver_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 58;
			end
			default: begin
				sender_idle_pct = 14;
				receiver_stall_pct = 14;
			end
		endcase
	endtask

	// One pixel request; valid stays high if the next request follows at once.
	task automatic send_pixel(logic [PIX_W-1:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= value;
		do @(posedge clk); while (!pixel_ready);
		sb.note_pixel(value);
	endtask

	// Register write; the caller lowers cfg_valid after its last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic end_config();
		cfg_valid <= 1'b0;
	endtask

	// Stop sending, wait for every predicted code, then let the pipeline settle.
	task automatic wait_drained();
		pixel_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] width_raw,
			logic [CFG_DATA_W-1:0] height_raw);
		write_reg(REG_IMAGE_WIDTH, width_raw);
		write_reg(REG_IMAGE_HEIGHT, height_raw);
		end_config();
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel(pix_style_t style, logic [PIX_W-1:0] base);
		case (style)
			PIX_NARROW: return base + PIX_W'($urandom_range(3));
			PIX_BINARY: return $urandom_range(1) ? 8'hff : 8'h00;
			default: return PIX_W'($urandom_range(255));
		endcase
	endfunction

	task automatic feed_pixels(int count);
		pix_style_t       style;
		logic [PIX_W-1:0] base;
		style = pix_style_t'($urandom_range(2));
		base = PIX_W'($urandom_range(255));
		repeat (count) send_pixel(rand_pixel(style, base));
	endtask

	// Mostly legal widths, with values below 3 and with the unused bit 11 set.
	function automatic logic [CFG_DATA_W-1:0] pick_width();
		case ($urandom_range(9))
			0: return CFG_DATA_W'($urandom_range(2));
			1: return 12'h800 | CFG_DATA_W'($urandom_range(3, 10));
			default: return CFG_DATA_W'($urandom_range(3, 12));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_height();
		if ($urandom_range(9) == 0) return CFG_DATA_W'($urandom_range(2));
		return CFG_DATA_W'($urandom_range(3, 8));
	endfunction

	initial begin
		logic [PIX_W-1:0] first_frame [9];
		logic [PIX_W-1:0] second_frame [16];
		int               seg;
		int               frame_pixels;
		int               count;

		first_frame = '{255, 0, 255, 0, 128, 255, 128, 0, 0};
		second_frame = '{0, 0, 0, 255, 0, 0, 255, 254, 0, 0, 128, 1, 0, 0, 3, 9};
		sb = new();
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		set_idling(IDLE_NONE);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: one frame at the reset size, with an equal neighbor.
		foreach (first_frame[i]) send_pixel(first_frame[i]);
		wait_drained();

		// Directed: 4x4 frame with flat zero centers and a saturated center.
		// After ten pixels, the sender waits for every code and the spare
		// indexes are written, which must not restart the frame.
		configure(12'd4, 12'd4);
		for (int i = 0; i < 16; i++) begin
			if (i == 10) begin
				wait_drained();
				write_reg(REG_SPARE_2, 12'hfff);
				write_reg(REG_SPARE_3, 12'h000);
				end_config();
			end
			send_pixel(second_frame[i]);
		end

		// Random: small frames, some cut short, under changing idling.
		seg = 0;
		random_sent = 0;
		while (random_sent < RANDOM_PIXELS) begin
			wait_drained();
			set_idling(idle_mode_t'(seg % 4));
			case ($urandom_range(3))
				0: configure(pick_width(), pick_height());
				1: begin
					write_reg(REG_IMAGE_WIDTH, pick_width());
					end_config();
				end
				2: begin
					write_reg(REG_IMAGE_HEIGHT, pick_height());
					end_config();
				end
				default: ;
			endcase
			repeat ($urandom_range(1, 3)) begin
				frame_pixels = sb.frame_width() * sb.frame_height();
				count = ($urandom_range(7) == 0) ?
					$urandom_range(1, frame_pixels - 1) : frame_pixels;
				feed_pixels(count);
				random_sent += count;
			end
			seg++;
		end

		// Tallest image: the first rows of a frame with the largest height.
		wait_drained();
		set_idling(IDLE_BOTH);
		configure(12'd3, 12'hfff);
		feed_pixels(3 * TALL_ROWS);
		wait_drained();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
